FILE: rtl/program_stream_demux_defines.svh
// assertion macros for the program stream demultiplexer
`ifndef PROGRAM_STREAM_DEMUX_DEFINES_SVH
`define PROGRAM_STREAM_DEMUX_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PSD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication
`define PSD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

FILE: rtl/psd_pkg.sv
// package: parse phases, stream kinds and the adts rate table
`timescale 1ns / 1ps
package psd_pkg;
  typedef enum logic [14:0] {
    PH_WAIT      = 15'b000000000000001,
    PH_PACK      = 15'b000000000000010,
    PH_STUFF     = 15'b000000000000100,
    PH_NEXT4     = 15'b000000000001000,
    PH_SYS_LEN   = 15'b000000000010000,
    PH_SYS_SKIP  = 15'b000000000100000,
    PH_MAP_LEN   = 15'b000000001000000,
    PH_MAP_HDR   = 15'b000000010000000,
    PH_MAP_INFO  = 15'b000000100000000,
    PH_MAP_ESLEN = 15'b000001000000000,
    PH_MAP_ENTRY = 15'b000010000000000,
    PH_MAP_ESINF = 15'b000100000000000,
    PH_MAP_TAIL  = 15'b001000000000000,
    PH_PES_HDR   = 15'b010000000000000,
    PH_PAYLOAD   = 15'b100000000000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_VIDEO = 2'd1,
    KIND_AUDIO = 2'd2
  } kind_t;

  localparam logic [1:0] CODEC_NONE = 2'd0;
  localparam logic [1:0] CODEC_G711 = 2'd1;
  localparam logic [1:0] CODEC_AAC  = 2'd2;

  localparam logic [7:0] SC_PACK = 8'hBA;
  localparam logic [7:0] SC_SYS  = 8'hBB;
  localparam logic [7:0] SC_MAP  = 8'hBC;
  localparam logic [7:0] ST_H264 = 8'h1B;
  localparam logic [7:0] ST_G711 = 8'h90;
  localparam logic [7:0] ST_AAC  = 8'h0F;

  typedef struct packed {
    logic [7:0]  es_byte;
    logic        es_kind;
    logic        new_pes;
    logic [32:0] pts_value;
    logic [1:0]  audio_codec;
    logic [16:0] sample_rate;
    logic [3:0]  channel_count;
  } result_t;

  function automatic logic [16:0] adts_rate(input logic [3:0] code);
    logic [16:0] r;
    case (code)
      4'd0:  r = 17'd96000;
      4'd1:  r = 17'd88200;
      4'd2:  r = 17'd64000;
      4'd3:  r = 17'd48000;
      4'd4:  r = 17'd44100;
      4'd5:  r = 17'd32000;
      4'd6:  r = 17'd24000;
      4'd7:  r = 17'd22050;
      4'd8:  r = 17'd16000;
      4'd9:  r = 17'd12000;
      4'd10: r = 17'd11025;
      4'd11: r = 17'd8000;
      4'd12: r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/psd_parser.sv
// byte parser: one stream byte in, at most one tagged payload byte out
`timescale 1ns / 1ps
`include "program_stream_demux_defines.svh"
module psd_parser
  import psd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    byte_en,
  input  logic [7:0] byte_in,
  output logic    res_en,
  output result_t res
);
  phase_t      phase_r, phase_nxt;
  logic [23:0] recent_r, recent_nxt;
  logic [15:0] fcnt_r, fcnt_nxt;
  logic [15:0] map_rem_r, map_rem_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic        started_r, started_nxt;
  logic [8:0]  vid_r, vid_nxt, aid_r, aid_nxt;
  logic [1:0]  codec_r, codec_nxt;
  logic        adts_done_r, adts_done_nxt;
  logic [16:0] rate_r, rate_nxt;
  logic [3:0]  chan_r, chan_nxt;
  logic [32:0] vpts_r, vpts_nxt, apts_r, apts_nxt;
  logic        first_pes_r, first_pes_nxt;
  kind_t       kind_r, kind_nxt;
  logic [39:0] pts_sh_r, pts_sh_nxt;
  logic [1:0]  next_stage_r, next_stage_nxt;
  logic [15:0] es_left_r, es_left_nxt;
  logic [7:0]  map_type_r, map_type_nxt;
  logic [1:0]  dfill_r, dfill_nxt;
  logic        take_vpts_r, take_vpts_nxt, adts_pend_r, adts_pend_nxt;
  logic        first_out_r, first_out_nxt;

  logic        prefix, match, emit;
  logic [39:0] sh_new;
  logic [32:0] pts_dec;
  logic [15:0] used, sk_cat, es_cat, pidx;
  logic [16:0] hdr_end;
  logic [3:0]  freq;
  logic [2:0]  ch;

  always_comb begin
    prefix  = recent_r == 24'h000001;
    match   = ({1'b0, byte_in} == vid_r) || ({1'b0, byte_in} == aid_r);
    sh_new  = {pts_sh_r[31:0], byte_in};
    pts_dec = {sh_new[35:33], sh_new[31:17], sh_new[15:1]};
    sk_cat  = {skip_r[15:8], byte_in};
    es_cat  = {es_left_r[15:8], byte_in};
    used    = sk_cat + 16'd4;
    hdr_end = {9'd0, hdr_r} + 17'd8;
    pidx    = fcnt_r - ({8'd0, hdr_r} + 16'd9);
    freq    = recent_r[5:2];
    ch      = {recent_r[0], byte_in[7:6]};
    emit    = 1'b0;

    phase_nxt = phase_r; recent_nxt = {recent_r[15:0], byte_in};
    fcnt_nxt = fcnt_r; map_rem_nxt = map_rem_r; skip_nxt = skip_r; hdr_nxt = hdr_r;
    started_nxt = started_r; vid_nxt = vid_r; aid_nxt = aid_r; codec_nxt = codec_r;
    adts_done_nxt = adts_done_r; rate_nxt = rate_r; chan_nxt = chan_r;
    vpts_nxt = vpts_r; apts_nxt = apts_r; first_pes_nxt = first_pes_r;
    kind_nxt = kind_r; pts_sh_nxt = pts_sh_r; next_stage_nxt = next_stage_r;
    es_left_nxt = es_left_r; map_type_nxt = map_type_r; dfill_nxt = dfill_r;
    take_vpts_nxt = take_vpts_r; adts_pend_nxt = adts_pend_r;
    first_out_nxt = first_out_r;

    if (prefix && byte_in == SC_PACK) begin
      phase_nxt = PH_PACK; fcnt_nxt = 16'd4; first_pes_nxt = 1'b1; dfill_nxt = 2'd0;
    end else begin
      case (phase_r)
        PH_PACK: begin
          if (fcnt_r == 16'd13) begin
            skip_nxt = {13'd0, byte_in[2:0]};
            fcnt_nxt = 16'd0;
            if (byte_in[2:0] != 3'd0) phase_nxt = PH_STUFF;
            else begin
              phase_nxt = PH_NEXT4; next_stage_nxt = 2'd0;
            end
          end else fcnt_nxt = fcnt_r + 16'd1;
        end
        PH_STUFF: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) begin
            phase_nxt = PH_NEXT4; next_stage_nxt = 2'd0; fcnt_nxt = 16'd0;
          end
        end
        PH_NEXT4: begin
          if (fcnt_r < 16'd3) fcnt_nxt = fcnt_r + 16'd1;
          else if (prefix && byte_in == SC_SYS && next_stage_r == 2'd0) begin
            phase_nxt = PH_SYS_LEN; fcnt_nxt = 16'd0;
          end else if (prefix && byte_in == SC_MAP && next_stage_r <= 2'd1) begin
            started_nxt = 1'b1; phase_nxt = PH_MAP_LEN; fcnt_nxt = 16'd0;
          end else if (prefix && started_r && match) begin
            // start of a pes
            kind_nxt = ({1'b0, byte_in} == vid_r) ? KIND_VIDEO : KIND_AUDIO;
            take_vpts_nxt = first_pes_r; first_pes_nxt = 1'b0;
            adts_pend_nxt = ({1'b0, byte_in} != vid_r) && !adts_done_r &&
                            codec_r == CODEC_AAC;
            phase_nxt = PH_PES_HDR; fcnt_nxt = 16'd4; dfill_nxt = 2'd0;
            first_out_nxt = 1'b1;
          end else phase_nxt = PH_WAIT;
        end
        PH_SYS_LEN: begin
          if (fcnt_r == 16'd0) begin
            skip_nxt = {byte_in, 8'd0}; fcnt_nxt = 16'd1;
          end else begin
            skip_nxt = sk_cat;
            if (sk_cat != 16'd0) phase_nxt = PH_SYS_SKIP;
            else begin
              phase_nxt = PH_NEXT4; next_stage_nxt = 2'd1; fcnt_nxt = 16'd0;
            end
          end
        end
        PH_SYS_SKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) begin
            phase_nxt = PH_NEXT4; next_stage_nxt = 2'd1; fcnt_nxt = 16'd0;
          end
        end
        PH_MAP_LEN: begin
          if (fcnt_r == 16'd0) begin
            map_rem_nxt = {byte_in, 8'd0}; fcnt_nxt = 16'd1;
          end else begin
            map_rem_nxt = {map_rem_r[15:8], byte_in};
            fcnt_nxt = 16'd0;
            if ({map_rem_r[15:8], byte_in} == 16'd0) begin
              phase_nxt = PH_NEXT4; next_stage_nxt = 2'd2;
            end else phase_nxt = PH_MAP_HDR;
          end
        end
        PH_MAP_HDR, PH_MAP_INFO, PH_MAP_ESLEN, PH_MAP_ENTRY, PH_MAP_ESINF,
        PH_MAP_TAIL: begin
          map_rem_nxt = map_rem_r - 16'd1;
          case (phase_r)
            PH_MAP_HDR: begin
              if (fcnt_r == 16'd2) skip_nxt = {byte_in, 8'd0};
              if (fcnt_r == 16'd3) begin
                skip_nxt = sk_cat; fcnt_nxt = 16'd0;
                phase_nxt = (sk_cat != 16'd0) ? PH_MAP_INFO : PH_MAP_ESLEN;
              end else fcnt_nxt = fcnt_r + 16'd1;
            end
            PH_MAP_INFO: begin
              skip_nxt = skip_r - 16'd1;
              if (skip_r == 16'd1) begin
                phase_nxt = PH_MAP_ESLEN; fcnt_nxt = 16'd0;
              end
            end
            PH_MAP_ESLEN: begin
              if (fcnt_r == 16'd0) begin
                es_left_nxt = {byte_in, 8'd0}; fcnt_nxt = 16'd1;
              end else begin
                es_left_nxt = es_cat; fcnt_nxt = 16'd0;
                phase_nxt = (es_cat != 16'd0) ? PH_MAP_ENTRY : PH_MAP_TAIL;
              end
            end
            PH_MAP_ENTRY: begin
              if (fcnt_r == 16'd0) begin
                map_type_nxt = byte_in; fcnt_nxt = 16'd1;
              end else if (fcnt_r == 16'd1) begin
                fcnt_nxt = 16'd2;
                if (map_type_r == ST_H264) vid_nxt = {1'b0, byte_in};
                else if (map_type_r == ST_G711) begin
                  aid_nxt = {1'b0, byte_in}; codec_nxt = CODEC_G711;
                  rate_nxt = 17'd8000; chan_nxt = 4'd1;
                end else if (map_type_r == ST_AAC) begin
                  aid_nxt = {1'b0, byte_in}; codec_nxt = CODEC_AAC;
                end
              end else if (fcnt_r == 16'd2) begin
                skip_nxt = {byte_in, 8'd0}; fcnt_nxt = 16'd3;
              end else begin
                skip_nxt = sk_cat; fcnt_nxt = 16'd0;
                // 4 + length overflows 16 bits only when it exceeds es_left anyway
                if (sk_cat < 16'hFFFC && es_left_r > used) es_left_nxt = es_left_r - used;
                else es_left_nxt = 16'd0;
                if (sk_cat != 16'd0) phase_nxt = PH_MAP_ESINF;
                else phase_nxt = (es_left_nxt != 16'd0) ? PH_MAP_ENTRY : PH_MAP_TAIL;
              end
            end
            PH_MAP_ESINF: begin
              skip_nxt = skip_r - 16'd1;
              if (skip_r == 16'd1) begin
                fcnt_nxt = 16'd0;
                phase_nxt = (es_left_r != 16'd0) ? PH_MAP_ENTRY : PH_MAP_TAIL;
              end
            end
            default: ;
          endcase
          if (map_rem_r == 16'd1) begin
            phase_nxt = PH_NEXT4; next_stage_nxt = 2'd2; fcnt_nxt = 16'd0;
          end
        end
        PH_PES_HDR: begin
          if (fcnt_r == 16'd8) hdr_nxt = byte_in;
          if (fcnt_r >= 16'd9 && fcnt_r <= 16'd13) begin
            pts_sh_nxt = sh_new;
            if (fcnt_r == 16'd13) begin
              if (kind_r == KIND_VIDEO) begin
                if (take_vpts_r) vpts_nxt = pts_dec;
              end else apts_nxt = pts_dec;
            end
          end
          if (fcnt_r != 16'hFFFF) fcnt_nxt = fcnt_r + 16'd1;
          if (fcnt_r >= 16'd8 && {1'b0, fcnt_r} >=
              ((fcnt_r == 16'd8) ? {9'd0, byte_in} + 17'd8 : hdr_end))
            phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (adts_pend_r && pidx == 16'd3) begin
            adts_pend_nxt = 1'b0;
            if (recent_r[23:16] != 8'hFF || recent_r[15:12] != 4'hF ||
                freq > 4'd12 || ch == 3'd0) begin
              phase_nxt = PH_WAIT;
            end else begin
              rate_nxt = adts_rate(freq);
              chan_nxt = (ch == 3'd7) ? 4'd8 : {1'b0, ch};
              adts_done_nxt = 1'b1;
            end
          end
          if (phase_nxt == PH_WAIT) begin
          end else if (dfill_r == 2'd3 && prefix && match) begin
            // start code inside the payload begins the next pes
            kind_nxt = ({1'b0, byte_in} == vid_r) ? KIND_VIDEO : KIND_AUDIO;
            take_vpts_nxt = first_pes_r; first_pes_nxt = 1'b0;
            adts_pend_nxt = ({1'b0, byte_in} != vid_r) && !adts_done_nxt &&
                            codec_r == CODEC_AAC;
            phase_nxt = PH_PES_HDR; fcnt_nxt = 16'd4; dfill_nxt = 2'd0;
            first_out_nxt = 1'b1;
          end else begin
            if (fcnt_r >= 16'd9 && fcnt_r <= 16'd13) begin
              pts_sh_nxt = sh_new;
              if (fcnt_r == 16'd13) begin
                if (kind_r == KIND_VIDEO) begin
                  if (take_vpts_r) vpts_nxt = pts_dec;
                end else apts_nxt = pts_dec;
              end
            end
            if (fcnt_r != 16'hFFFF) fcnt_nxt = fcnt_r + 16'd1;
            if (dfill_r != 2'd3) dfill_nxt = dfill_r + 2'd1;
            else begin
              emit = 1'b1; first_out_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT; recent_r <= '0; fcnt_r <= '0; map_rem_r <= '0;
      skip_r <= '0; hdr_r <= '0; started_r <= 1'b0; vid_r <= 9'h1FF; aid_r <= 9'h1FF;
      codec_r <= CODEC_NONE; adts_done_r <= 1'b0; rate_r <= '0; chan_r <= '0;
      vpts_r <= '0; apts_r <= '0; first_pes_r <= 1'b1; kind_r <= KIND_NONE;
      pts_sh_r <= '0; next_stage_r <= '0; es_left_r <= '0; map_type_r <= '0;
      dfill_r <= '0; take_vpts_r <= 1'b0; adts_pend_r <= 1'b0; first_out_r <= 1'b0;
      res_en <= 1'b0;
    end else begin
      res_en <= byte_en && emit;
      if (byte_en) begin
        phase_r <= phase_nxt; recent_r <= recent_nxt; fcnt_r <= fcnt_nxt;
        map_rem_r <= map_rem_nxt; skip_r <= skip_nxt; hdr_r <= hdr_nxt;
        started_r <= started_nxt; vid_r <= vid_nxt; aid_r <= aid_nxt;
        codec_r <= codec_nxt; adts_done_r <= adts_done_nxt; rate_r <= rate_nxt;
        chan_r <= chan_nxt; vpts_r <= vpts_nxt; apts_r <= apts_nxt;
        first_pes_r <= first_pes_nxt; kind_r <= kind_nxt; pts_sh_r <= pts_sh_nxt;
        next_stage_r <= next_stage_nxt; es_left_r <= es_left_nxt;
        map_type_r <= map_type_nxt; dfill_r <= dfill_nxt;
        take_vpts_r <= take_vpts_nxt; adts_pend_r <= adts_pend_nxt;
        first_out_r <= first_out_nxt;
      end
    end
  end

  // result register: pts and adts fields include any latch made by this byte
  always_ff @(posedge clk) begin
    if (byte_en && emit) begin
      res.es_byte       <= recent_r[23:16];
      res.es_kind       <= kind_r == KIND_AUDIO;
      res.new_pes       <= first_out_r;
      res.pts_value     <= (kind_r == KIND_AUDIO) ? apts_nxt : vpts_nxt;
      res.audio_codec   <= codec_r;
      res.sample_rate   <= rate_nxt;
      res.channel_count <= chan_nxt;
    end
  end

  `PSD_ASSERT_IMP(a_no_emit_before_map, clk, rst_n, !started_r, !(byte_en && emit))
  `PSD_ASSERT_IMP(a_emit_in_payload, clk, rst_n, byte_en && emit,
                  phase_r == PH_PAYLOAD && dfill_r == 2'd3)
  `PSD_ASSERT_NEXT(a_pack_resets_delay, clk, rst_n,
                   byte_en && recent_r == 24'h000001 && byte_in == SC_PACK,
                   phase_r == PH_PACK && dfill_r == 2'd0)
endmodule

FILE: rtl/program_stream_demux.sv
// top level: program stream demultiplexer with skid-buffered output
`timescale 1ns / 1ps
// Takes one program-stream byte per clock and gives at most one tagged
// payload byte per input byte, three bytes late: a payload byte is written to
// the parser's result register when the third byte behind it is accepted,
// then enters the output queue and is offered. A byte is accepted whenever the
// four-entry output queue has room for every result still in flight, so the
// rate is one byte per cycle while the consumer keeps up; input stalls only
// once the queue has backed up. Parsing is one registered pass per byte through
// the pack, system header, stream map and PES header fields.
`include "program_stream_demux_defines.svh"
module program_stream_demux
  import psd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_es_byte,
  output logic        out_es_kind,
  output logic        out_new_pes,
  output logic [32:0] out_pts_value,
  output logic [1:0]  out_audio_codec,
  output logic [16:0] out_sample_rate,
  output logic [3:0]  out_channel_count
);
  logic    res_en;
  result_t res;
  result_t q_r [4];
  logic [2:0] cnt_r;
  logic [1:0] rd_ptr_r, wr_ptr_r;
  logic    pop, acc;

  assign acc = in_valid && in_ready;
  // one result may already be in flight from the parser register
  assign in_ready = (cnt_r + {2'b00, res_en}) < 3'd4;
  assign out_valid = cnt_r != 3'd0;
  assign pop = out_valid && out_ready;

  psd_parser u_parser (
    .clk(clk), .rst_n(rst_n), .byte_en(acc), .byte_in(in_byte),
    .res_en(res_en), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_ptr_r <= '0; wr_ptr_r <= '0;
    end else begin
      if (res_en) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {2'b00, res_en} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) q_r[wr_ptr_r] <= res;
  end

  assign out_es_byte       = q_r[rd_ptr_r].es_byte;
  assign out_es_kind       = q_r[rd_ptr_r].es_kind;
  assign out_new_pes       = q_r[rd_ptr_r].new_pes;
  assign out_pts_value     = q_r[rd_ptr_r].pts_value;
  assign out_audio_codec   = q_r[rd_ptr_r].audio_codec;
  assign out_sample_rate   = q_r[rd_ptr_r].sample_rate;
  assign out_channel_count = q_r[rd_ptr_r].channel_count;

  `PSD_ASSERT_IMP(a_no_overflow, clk, rst_n, res_en, cnt_r != 3'd4)
  `PSD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, cnt_r <= 3'd4)
  `PSD_ASSERT_NEXT(a_hold_when_full, clk, rst_n, cnt_r == 3'd4 && !out_ready,
                   $stable(rd_ptr_r))
endmodule

FILE: dv/tb_top.sv
// testbench for the program stream demultiplexer: generated streams, inline predictor
`timescale 1ns / 1ps
module tb_top
  import psd_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PAUSE_MARK     = -1;
  localparam logic [7:0] ST_OTHER = 8'h03;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_es_byte;
  logic        out_es_kind;
  logic        out_new_pes;
  logic [32:0] out_pts_value;
  logic [1:0]  out_audio_codec;
  logic [16:0] out_sample_rate;
  logic [3:0]  out_channel_count;

  program_stream_demux DUT (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  phase_t          ph;
  logic [23:0]     recent;
  int unsigned     fc, skip, hdr_len, es_left, nstage, dfill;
  logic [15:0]     map_rem;
  logic [8:0]      vid, aid;
  logic [1:0]      codec;
  logic [16:0]     rate;
  logic [3:0]      chans;
  logic [32:0]     vpts, apts;
  logic [39:0]     pts_sr;
  logic [7:0]      mtype;
  kind_t           kind;
  bit              started, adts_done, first_pes, take_vpts, adts_pend, first_out;

  logic [16:0] rate_tab [13] = '{17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100,
    17'd32000, 17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000, 17'd7350};

  int       stream_q [$];
  result_t  payload_q [$];
  int       n_bytes, n_results, n_video, n_audio, n_new, n_packs, errors, wd_count;
  bit       quiet_in, quiet_out;

  function automatic void demux_reset();
    ph = PH_WAIT; recent = '0; fc = 0; skip = 0; hdr_len = 0; es_left = 0; nstage = 0;
    dfill = 0; map_rem = '0; vid = 9'h1FF; aid = 9'h1FF; codec = CODEC_NONE; rate = '0;
    chans = '0; vpts = '0; apts = '0; pts_sr = '0; mtype = '0; kind = KIND_NONE;
    started = 0; adts_done = 0; first_pes = 1; take_vpts = 0; adts_pend = 0; first_out = 0;
  endfunction

  function automatic void to_next4(int unsigned stage);
    ph = PH_NEXT4; nstage = stage; fc = 0;
  endfunction

  function automatic void open_pes(logic [7:0] id);
    kind = ({1'b0, id} == vid) ? KIND_VIDEO : KIND_AUDIO;
    take_vpts = first_pes;
    first_pes = 0;
    adts_pend = (kind == KIND_AUDIO) && !adts_done && codec == CODEC_AAC;
    ph = PH_PES_HDR; fc = 4; dfill = 0; first_out = 1;
  endfunction

  function automatic void entry_done();
    ph = (es_left != 0) ? PH_MAP_ENTRY : PH_MAP_TAIL;
    fc = 0;
  endfunction

  function automatic void map_step(logic [7:0] b);
    int unsigned used;
    map_rem = map_rem - 16'd1;
    case (ph)
      PH_MAP_HDR: begin
        if (fc == 2) skip = {b, 8'h00};
        if (fc == 3) skip = skip | b;
        fc++;
        if (fc == 4) begin
          ph = (skip != 0) ? PH_MAP_INFO : PH_MAP_ESLEN;
          fc = 0;
        end
      end
      PH_MAP_INFO: begin
        skip--;
        if (skip == 0) begin
          ph = PH_MAP_ESLEN; fc = 0;
        end
      end
      PH_MAP_ESLEN: begin
        if (fc == 0) begin
          es_left = {b, 8'h00}; fc = 1;
        end else begin
          es_left = es_left | b;
          entry_done();
        end
      end
      PH_MAP_ENTRY: begin
        if (fc == 0) begin
          mtype = b; fc++;
        end else if (fc == 1) begin
          if (mtype == ST_H264) vid = {1'b0, b};
          else if (mtype == ST_G711) begin
            aid = {1'b0, b}; codec = CODEC_G711; rate = 17'd8000; chans = 4'd1;
          end else if (mtype == ST_AAC) begin
            aid = {1'b0, b}; codec = CODEC_AAC;
          end
          fc++;
        end else if (fc == 2) begin
          skip = {b, 8'h00}; fc++;
        end else begin
          skip = skip | b;
          used = 4 + skip;
          es_left = (es_left > used) ? es_left - used : 0;
          if (skip != 0) begin
            ph = PH_MAP_ESINF; fc = 0;
          end else entry_done();
        end
      end
      PH_MAP_ESINF: begin
        skip--;
        if (skip == 0) entry_done();
      end
      default: ;
    endcase
    if (map_rem == 0) to_next4(2);
  endfunction

  function automatic void pts_step(int unsigned idx, logic [7:0] b);
    logic [7:0]  top;
    logic [32:0] p;
    if (idx >= 9 && idx <= 13) begin
      pts_sr = {pts_sr[31:0], b};
      if (idx == 13) begin
        top = pts_sr[39:32] & 8'h0E;
        p = ({25'd0, top} << 29) | ({18'd0, pts_sr[31:17]} << 15) | {18'd0, pts_sr[15:1]};
        if (kind == KIND_VIDEO) begin
          if (take_vpts) vpts = p;
        end else apts = p;
      end
    end
  endfunction

  // returns 1 when the byte releases a payload item
  function automatic bit demux_step(logic [7:0] b, output result_t r);
    logic [23:0] prev;
    bit          prefix, hit;
    int unsigned idx, pidx;
    logic [3:0]  freq;
    logic [2:0]  ch;
    prev = recent;
    prefix = (prev == 24'h000001);
    hit = ({1'b0, b} == vid) || ({1'b0, b} == aid);
    recent = {prev[15:0], b};
    r = '0;
    if (prefix && b == SC_PACK) begin
      ph = PH_PACK; fc = 4; first_pes = 1; dfill = 0;
      return 0;
    end
    case (ph)
      PH_PACK: begin
        if (fc == 13) begin
          skip = b & 8'h07;
          if (skip != 0) begin
            ph = PH_STUFF; fc = 0;
          end else to_next4(0);
        end else fc++;
      end
      PH_STUFF: begin
        skip--;
        if (skip == 0) to_next4(0);
      end
      PH_NEXT4: begin
        if (fc < 3) fc++;
        else if (prefix && b == SC_SYS && nstage == 0) begin
          ph = PH_SYS_LEN; fc = 0;
        end else if (prefix && b == SC_MAP && nstage <= 1) begin
          started = 1; ph = PH_MAP_LEN; fc = 0;
        end else if (prefix && started && hit) open_pes(b);
        else ph = PH_WAIT;
      end
      PH_SYS_LEN: begin
        if (fc == 0) begin
          skip = {b, 8'h00}; fc = 1;
        end else begin
          skip = skip | b;
          if (skip != 0) ph = PH_SYS_SKIP;
          else to_next4(1);
        end
      end
      PH_SYS_SKIP: begin
        skip--;
        if (skip == 0) to_next4(1);
      end
      PH_MAP_LEN: begin
        if (fc == 0) begin
          map_rem = {b, 8'h00}; fc = 1;
        end else begin
          map_rem = map_rem | b;
          if (map_rem == 0) to_next4(2);
          else begin
            ph = PH_MAP_HDR; fc = 0;
          end
        end
      end
      PH_MAP_HDR, PH_MAP_INFO, PH_MAP_ESLEN, PH_MAP_ENTRY, PH_MAP_ESINF, PH_MAP_TAIL:
        map_step(b);
      PH_PES_HDR: begin
        idx = fc;
        if (idx == 8) hdr_len = b;
        pts_step(idx, b);
        if (fc < 32'hFFFF) fc++;
        if (idx >= 8 && idx >= hdr_len + 8) ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        idx = fc;
        pidx = idx - (hdr_len + 9);
        if (adts_pend && pidx == 3) begin
          adts_pend = 0;
          freq = prev[5:2];
          ch = {prev[0], b[7:6]};
          if (prev[23:16] != 8'hFF || prev[15:12] != 4'hF || freq > 12 || ch == 0) begin
            ph = PH_WAIT;
            return 0;
          end
          rate = rate_tab[freq];
          chans = (ch == 3'd7) ? 4'd8 : {1'b0, ch};
          adts_done = 1;
        end
        if (dfill == 3 && prefix && hit) begin
          open_pes(b);
          return 0;
        end
        pts_step(idx, b);
        if (fc < 32'hFFFF) fc++;
        if (dfill < 3) begin
          dfill++;
          return 0;
        end
        r.es_byte = prev[23:16];
        r.es_kind = (kind == KIND_AUDIO);
        r.new_pes = first_out;
        r.pts_value = (kind == KIND_AUDIO) ? apts : vpts;
        r.audio_codec = codec;
        r.sample_rate = rate;
        r.channel_count = chans;
        first_out = 0;
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // stream generation
  logic [7:0] g_vid, g_aid;
  bit         g_aac;

  task automatic put(int b);
    stream_q.push_back(b & 8'hFF);
  endtask

  task automatic put_code(logic [7:0] code);
    put(8'h00); put(8'h00); put(8'h01); put(code);
  endtask

  task automatic put_rand(int n);
    repeat (n) put($urandom_range(255));
  endtask

  task automatic gen_map(bit aac, bit junk);
    int info, ei1, ei2, es_len, mlen;
    info = $urandom_range(3);
    ei1 = $urandom_range(2);
    ei2 = $urandom_range(2);
    es_len = 8 + ei1 + ei2 + (junk ? 4 : 0);
    mlen = 4 + info + 2 + es_len + 4;
    if ($urandom_range(9) == 0) mlen = mlen + $urandom_range(6) - 3;
    put_code(SC_MAP);
    put(mlen >> 8); put(mlen);
    put($urandom_range(255)); put($urandom_range(255)); put(0); put(info); put_rand(info);
    if ($urandom_range(9) == 0) es_len = $urandom_range(es_len);
    put(es_len >> 8); put(es_len);
    put(ST_H264); put(g_vid); put(0); put(ei1); put_rand(ei1);
    if (junk) begin
      put(ST_OTHER); put($urandom_range(255)); put(0); put(0);
    end
    put(aac ? ST_AAC : ST_G711); put(g_aid); put(0); put(ei2); put_rand(ei2);
    put_rand(4);
  endtask

  task automatic gen_pes(logic [7:0] id, int plen, bit adts_bad);
    int hl, fq, ch;
    hl = ($urandom_range(5) == 0) ? $urandom_range(12) : 5;
    put_code(id);
    put($urandom_range(255)); put($urandom_range(255));
    put(8'h80); put(8'h80); put(hl);
    put_rand(hl);
    if (id == g_aid && g_aac && plen >= 4) begin
      fq = adts_bad ? $urandom_range(15) : $urandom_range(12);
      ch = adts_bad ? $urandom_range(7) : $urandom_range(7, 1);
      put(adts_bad && $urandom_range(1) ? 8'hFE : 8'hFF);
      put(8'hF1);
      put((fq << 2) | (ch >> 2));
      put((ch & 3) << 6);
      plen = plen - 4;
    end
    repeat (plen) begin
      // occasional embedded start code with a random stream id
      if ($urandom_range(40) == 0) begin
        put(0); put(0); put(1); put($urandom_range(255));
      end else put($urandom_range(255));
    end
  endtask

  task automatic gen_pack(bit with_map, bit with_sys, int npes);
    int stuff;
    logic [7:0] id;
    n_packs++;
    stuff = $urandom_range(7);
    put_code(SC_PACK);
    put_rand(9);
    put(($urandom_range(31) << 3) | stuff);
    put_rand(stuff);
    if (with_sys) begin
      put_code(SC_SYS); put(0); put($urandom_range(6)); put_rand(stream_q[$]);
    end
    if (with_map) gen_map(g_aac, $urandom_range(3) == 0);
    repeat (npes) begin
      case ($urandom_range(9))
        0: id = 8'($urandom_range(255));
        1, 2, 3, 4: id = g_vid;
        default: id = g_aid;
      endcase
      gen_pes(id, ($urandom_range(7) == 0) ? $urandom_range(3) : $urandom_range(40),
              $urandom_range(12) == 0);
    end
  endtask

  // driver
  always @(posedge clk) begin
    result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_bytes++;
        if (demux_step(in_byte, r)) payload_q.push_back(r);
      end
      if (!in_valid || in_ready) begin
        if (stream_q.size() > 0 && stream_q[0] == PAUSE_MARK && payload_q.size() == 0)
          void'(stream_q.pop_front());
        quiet_in = (n_bytes > 250 && n_bytes < 420);
        if (stream_q.size() > 0 && stream_q[0] != PAUSE_MARK &&
            (quiet_in || $urandom_range(99) >= 38)) begin
          in_byte  <= 8'(stream_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_es_byte, out_es_kind, out_new_pes, out_pts_value, out_audio_codec,
                out_sample_rate, out_channel_count};
        if (payload_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item: %p", got);
        end else begin
          want = payload_q.pop_front();
          n_results++;
          if (want.es_kind) n_audio++; else n_video++;
          if (want.new_pes) n_new++;
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      quiet_out = (n_results > 120 && n_results < 260);
      out_ready <= quiet_out || ($urandom_range(99) >= 38);
      if ((in_valid && in_ready) || (out_valid && out_ready)) wd_count = 0;
      else wd_count++;
      if (wd_count >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d items outstanding", payload_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    demux_reset();
    // bytes before any map are ignored, including a pack without a map
    put_rand(6);
    g_vid = 8'hE0; g_aid = 8'hC0; g_aac = 1;
    gen_pack(0, 0, 2);
    // directed: system header, map with video and aac entries, extreme payload bytes
    gen_pack(1, 1, 0);
    gen_pes(g_vid, 6, 0);
    put(8'h00); put(8'hFF); put(8'h00); put(8'hFF);
    gen_pes(g_aid, 8, 0);
    gen_pes(g_aid, 8, 1);
    stream_q.push_back(PAUSE_MARK);
    g_aac = 0; g_aid = 8'hC1;
    gen_pack(1, 0, 3);
    stream_q.push_back(PAUSE_MARK);
    // random part
    while (stream_q.size() < 600) begin
      if ($urandom_range(7) == 0) begin
        g_vid = 8'(8'hE0 + $urandom_range(15));
        g_aid = 8'(8'hC0 + $urandom_range(31));
        g_aac = 1'($urandom_range(1));
      end
      if ($urandom_range(15) == 0) put_rand($urandom_range(20));
      gen_pack($urandom_range(3) != 0, $urandom_range(2) == 0, $urandom_range(4, 1));
      if ($urandom_range(5) == 0) stream_q.push_back(PAUSE_MARK);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (stream_q.size() > 0 || in_valid || payload_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d stream bytes in %0d packs, %0d payload items (%0d video, %0d audio)",
             n_bytes, n_packs, n_results, n_video, n_audio);
    $display("%0d pes starts seen, %0d errors", n_new, errors);
    if (errors == 0 && payload_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: program_stream_demux.f
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_parser.sv
rtl/program_stream_demux.sv
dv/tb_top.sv
